@@ hdl/rls_pkg.sv @@
// ============================================================================
// rls_pkg
// Shared types and constants for the reversible LIFO stack unit.
// ============================================================================
package rls_pkg;

    // Stack geometry
    localparam int DEPTH  = 8;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SH_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W  = 4;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    // Operation codes carried on the input tuser
    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_PEEK    = 2'd2,
        OP_REVERSE = 2'd3
    } op_t;

    // Result status codes carried on the output tuser
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // Controller states: output register empty or holding a result
    typedef enum logic {
        CTRL_IDLE = 1'b0,
        CTRL_HOLD = 1'b1
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    exec;
        logic    push;
        logic    pop;
        logic    reverse;
        logic    read_top;
        status_t status;
    } rls_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
    } rls_stat_t;

endpackage

@@ hdl/rls_ctrl.sv @@
// ============================================================================
// rls_ctrl
// Handshake controller: accepts transactions, decodes the operation against
// the stack flags and drives the datapath commands.
// ============================================================================
module rls_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [rls_pkg::OP_W-1:0] s_op,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  rls_pkg::rls_stat_t stat,
    output rls_pkg::rls_cmd_t  cmd
);
    import rls_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    op_t         op;
    logic        accept;

    assign op = op_t'(s_op);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTRL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state, handshake and command decode
    always_comb
    begin
        s_tready   = (state_reg == CTRL_IDLE) || m_tready;
        m_tvalid   = (state_reg == CTRL_HOLD);
        accept     = s_tvalid && s_tready;
        state_next = state_reg;

        case (state_reg)
            CTRL_IDLE:
            begin
                if (accept)
                begin
                    state_next = CTRL_HOLD;
                end
            end
            CTRL_HOLD:
            begin
                if (!accept && m_tready)
                begin
                    state_next = CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = CTRL_IDLE;
            end
        endcase

        cmd          = '0;
        cmd.exec     = accept;
        cmd.status   = ST_OK;
        case (op)
            OP_PUSH:
            begin
                if (stat.full)
                begin
                    cmd.status = ST_OVERFLOW;
                end
                else
                begin
                    cmd.push = accept;
                end
            end
            OP_POP:
            begin
                if (stat.empty)
                begin
                    cmd.status = ST_UNDERFLOW;
                end
                else
                begin
                    cmd.pop      = accept;
                    cmd.read_top = 1'b1;
                end
            end
            OP_PEEK:
            begin
                if (stat.empty)
                begin
                    cmd.status = ST_UNDERFLOW;
                end
                else
                begin
                    cmd.read_top = 1'b1;
                end
            end
            default:
            begin
                cmd.reverse = accept;
            end
        endcase
    end

endmodule

@@ hdl/rls_datapath.sv @@
// ============================================================================
// rls_datapath
// Shift-register stack with top at entry zero, a mirror-and-shift network
// for reversal, and the result register.
// ============================================================================
module rls_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  rls_pkg::rls_cmd_t           cmd,
    input  logic [rls_pkg::DATA_W-1:0]  push_value,
    output rls_pkg::rls_stat_t          stat,
    output logic [rls_pkg::DATA_W-1:0]  read_value,
    output logic [rls_pkg::STAT_W-1:0]  status,
    output logic [rls_pkg::OCC_W-1:0]   occupancy
);
    import rls_pkg::*;

    logic [DATA_W-1:0] entries_reg  [DEPTH];
    logic [DATA_W-1:0] entries_next [DEPTH];
    logic [DATA_W-1:0] mirror       [DEPTH];
    logic [DATA_W-1:0] stage        [SH_W+1][DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [SH_W-1:0]   shift_amt;
    logic [DATA_W-1:0] read_reg;
    logic [STAT_W-1:0] status_reg;
    logic [OCC_W-1:0]  occ_reg;

    // Stack flags
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));

    // Reversal: mirror the whole array, then shift up by the unused depth
    assign shift_amt = SH_W'(CNT_W'(DEPTH) - count_reg);

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            mirror[i]   = entries_reg[DEPTH-1-i];
            stage[0][i] = mirror[i];
        end
        for (int k = 0; k < SH_W; k++)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (!shift_amt[k])
                begin
                    stage[k+1][i] = stage[k][i];
                end
                else if (i + (1 << k) < DEPTH)
                begin
                    stage[k+1][i] = stage[k][i + (1 << k)];
                end
                else
                begin
                    stage[k+1][i] = '0;
                end
            end
        end
    end

    // Next stack contents and count
    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            entries_next[i] = entries_reg[i];
        end
        if (cmd.push)
        begin
            entries_next[0] = push_value;
            for (int i = 1; i < DEPTH; i++)
            begin
                entries_next[i] = entries_reg[i-1];
            end
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                entries_next[i] = entries_reg[i+1];
            end
            count_next = count_reg - 1'b1;
        end
        else if (cmd.reverse && (count_reg > CNT_W'(1)))
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                entries_next[i] = stage[SH_W][i];
            end
        end
    end

    // Stack storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            entries_reg[i] <= entries_next[i];
        end
    end

    // Occupancy count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Result register: load on each accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            read_reg   <= cmd.read_top ? entries_reg[0] : '0;
            status_reg <= cmd.status;
            occ_reg    <= OCC_W'(count_next);
        end
    end

    assign read_value = read_reg;
    assign status     = status_reg;
    assign occupancy  = occ_reg;

endmodule

@@ hdl/reversible_lifo_stack_unit.sv @@
// ============================================================================
// reversible_lifo_stack_unit
// LIFO stack of signed words with push, pop, peek and reverse operations.
// ============================================================================
// Output: each result is registered and appears in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle while the output is empty or accepted;
//   every stack update is a parallel shift or mirror of the register stack.
// Reset: the stack count clears to zero and the output goes empty; stack words
//   are not cleared and are only read once written.
module reversible_lifo_stack_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] push_value
    input  logic [1:0]  s_tuser,   // [1:0] func
    // Output channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] read_value, [35:32] occupancy, zero pad
    output logic [1:0]  m_tuser    // [1:0] status
);
    import rls_pkg::*;

    rls_cmd_t          cmd;
    rls_stat_t         stat;
    logic [DATA_W-1:0] read_value;
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occupancy;

    // Controller
    rls_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    rls_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .push_value (s_tdata),
        .stat       (stat),
        .read_value (read_value),
        .status     (status),
        .occupancy  (occupancy)
    );

    // Pack result fields
    assign m_tdata = {4'b0000, occupancy, read_value};
    assign m_tuser = status;

endmodule
